// ===== rtl/sas_pkg.sv =====
package sas_pkg;

    // Field and storage widths.
    localparam int DUR_W       = 16;
    localparam int FW_W        = 12;
    localparam int TIU_W       = 3;
    localparam int TABLE_W     = 32;
    localparam int LINKS_W     = 12;
    localparam int LINK_W      = 3;
    localparam int ROW_W       = 2;
    localparam int OFFSET_W    = 24;
    localparam int TIME_W      = 24;
    localparam int SUM_W       = TIME_W + 1;
    localparam int LEN_W       = 24;
    localparam int FRAME_W     = 8;
    localparam int ELAPSED_W   = 16;
    localparam int X_W         = 20;
    localparam int Y_W         = 14;
    localparam int CNT_W       = 5;

    // Shift-subtract step counts of the shared divider.
    localparam int MOD_STEPS   = SUM_W;
    localparam int FRAME_STEPS = FRAME_W;

    // Stream and configuration port widths.
    localparam int S_DATA_W    = 24;
    localparam int S_USER_W    = 2;
    localparam int M_DATA_W    = 64;
    localparam int M_USER_W    = 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_SET   = 2'd1,
        KIND_PAUSE = 2'd2,
        KIND_START = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CFG_DURATION  = 3'd0,
        CFG_WIDTH     = 3'd1,
        CFG_HEIGHT    = 3'd2,
        CFG_TIMELINES = 3'd3,
        CFG_FRAMES    = 3'd4,
        CFG_LINKS     = 3'd5,
        CFG_START_ROW = 3'd6,
        CFG_START_OFS = 3'd7
    } t_cfg_idx;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic capture;
        logic start_apply;
        logic pause_apply;
        logic set_apply;
        logic mod_load;
        logic tick_apply;
        logic len_load;
        logic frame_load;
        logic div_step;
        logic frame_apply;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        t_kind kind;
        logic  tick_live;
        logic  set_switch;
        logic  link_switch;
        logic  div_done;
        logic  out_free;
    } t_status;

endpackage

// ===== rtl/sas_ctrl.sv =====
module sas_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  sas_pkg::t_status i_status,
    output logic             o_in_ready,
    output sas_pkg::t_cmd    o_cmd
);
    import sas_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE        = 9'b000000001,
        S_DECODE      = 9'b000000010,
        S_MOD         = 9'b000000100,
        S_TICK_APPLY  = 9'b000001000,
        S_LEN         = 9'b000010000,
        S_FRAME_LOAD  = 9'b000100000,
        S_FRAME_RUN   = 9'b001000000,
        S_FRAME_APPLY = 9'b010000000,
        S_OUT         = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.kind)
                    KIND_START: begin
                        o_cmd.start_apply = 1'b1;
                        n_state           = S_LEN;
                    end
                    KIND_PAUSE: begin
                        o_cmd.pause_apply = 1'b1;
                        n_state           = S_OUT;
                    end
                    KIND_SET: begin
                        o_cmd.set_apply = 1'b1;
                        n_state         = i_status.set_switch ? S_LEN : S_OUT;
                    end
                    KIND_TICK: begin
                        if (i_status.tick_live) begin
                            o_cmd.mod_load = 1'b1;
                            n_state        = S_MOD;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_MOD: begin
                if (i_status.div_done) begin
                    n_state = S_TICK_APPLY;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_TICK_APPLY: begin
                o_cmd.tick_apply = 1'b1;
                n_state          = i_status.link_switch ? S_LEN : S_FRAME_LOAD;
            end
            S_LEN: begin
                o_cmd.len_load = 1'b1;
                n_state        = (i_status.kind == KIND_SET) ? S_OUT : S_FRAME_LOAD;
            end
            S_FRAME_LOAD: begin
                o_cmd.frame_load = 1'b1;
                n_state          = S_FRAME_RUN;
            end
            S_FRAME_RUN: begin
                if (i_status.div_done) begin
                    n_state = S_FRAME_APPLY;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FRAME_APPLY: begin
                o_cmd.frame_apply = 1'b1;
                n_state           = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/sas_datapath.sv =====
module sas_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sas_pkg::t_cmd                     i_cmd,
    output sas_pkg::t_status                  o_status,
    input  logic                              i_cfg_valid,
    input  logic [sas_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sas_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [1:0]                        i_kind,
    input  logic [sas_pkg::ELAPSED_W-1:0]     i_elapsed,
    input  logic [sas_pkg::ROW_W-1:0]         i_target_row,
    input  logic                              i_emit_on_switch,
    input  logic                              i_pause_value,
    input  logic                              i_m_ready,
    output logic                              o_m_valid,
    output logic [sas_pkg::M_DATA_W-1:0]      o_m_data,
    output logic [sas_pkg::M_USER_W-1:0]      o_m_user
);
    import sas_pkg::*;

    // Configuration registers.
    logic [DUR_W-1:0]    r_cfg_dur;
    logic [FW_W-1:0]     r_cfg_fw;
    logic [FW_W-1:0]     r_cfg_fh;
    logic [TIU_W-1:0]    r_cfg_tiu;
    logic [TABLE_W-1:0]  r_cfg_frames;
    logic [LINKS_W-1:0]  r_cfg_links;
    logic [ROW_W-1:0]    r_cfg_srow;
    logic [OFFSET_W-1:0] r_cfg_soff;

    // Captured item.
    t_kind                r_kind;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [ROW_W-1:0]     r_target;
    logic                 r_emit_sw;
    logic                 r_pval;

    // Animation state.
    logic [ROW_W-1:0]   r_row;
    logic [TIME_W-1:0]  r_time;
    logic [FRAME_W-1:0] r_frame;
    logic               r_forced;
    logic [LEN_W-1:0]   r_len;
    logic               r_pause;
    logic               r_emit;
    logic               r_bad;
    logic               r_wrap;
    logic               r_sat;

    // Shared shift-subtract divider.
    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_dvd;
    logic [LEN_W-1:0] r_dsr;
    logic [CNT_W-1:0] r_cnt;

    // Output stage.
    logic             r_m_valid;
    logic [X_W-1:0]   r_x;
    logic [Y_W-1:0]   r_y;
    logic [FW_W-1:0]  r_w;
    logic [FW_W-1:0]  r_h;
    logic [ROW_W-1:0] r_o_row;
    logic             r_o_pause;
    logic             r_o_bad;
    logic             r_o_emit;

    logic [DUR_W-1:0]   dur_eff;
    logic [FRAME_W-1:0] cur_frames;
    logic [LINK_W-1:0]  link;
    logic               linked;
    logic               start_ok;
    logic               target_ok;
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   shifted;
    logic               step_ge;
    logic [FRAME_W-1:0] quot_frame;
    logic               link_switch;
    logic               out_free;

    function automatic logic [FRAME_W-1:0] frames_of(input logic [TABLE_W-1:0] tbl,
                                                     input logic [ROW_W-1:0]   row);
        logic [FRAME_W-1:0] c;
        c = tbl[{row, 3'b000} +: FRAME_W];
        return (c == '0) ? FRAME_W'(1) : c;
    endfunction

    function automatic logic [LINK_W-1:0] link_of(input logic [LINKS_W-1:0] tbl,
                                                  input logic [ROW_W-1:0]   row);
        logic [LINK_W-1:0] l;
        case (row)
            2'd0:    l = tbl[2:0];
            2'd1:    l = tbl[5:3];
            2'd2:    l = tbl[8:6];
            default: l = tbl[11:9];
        endcase
        return l;
    endfunction

    assign dur_eff     = (r_cfg_dur == '0) ? DUR_W'(1) : r_cfg_dur;
    assign cur_frames  = frames_of(r_cfg_frames, r_row);
    assign link        = link_of(r_cfg_links, r_row);
    // A link is taken only to a row that is in use; code 7 and codes 4 to 6 mean none.
    assign linked      = !link[LINK_W-1] && (link < r_cfg_tiu);
    assign start_ok    = ({1'b0, r_cfg_srow} < r_cfg_tiu);
    assign target_ok   = ({1'b0, r_target} < r_cfg_tiu);
    assign sum         = {1'b0, r_time} + SUM_W'(r_elapsed);
    assign shifted     = {r_rem[SUM_W-2:0], r_dvd[SUM_W-1]};
    assign step_ge     = (shifted >= {1'b0, r_dsr});
    assign quot_frame  = r_sat ? {FRAME_W{1'b1}} : r_dvd[FRAME_W-1:0];
    assign link_switch = r_wrap && (link[ROW_W-1:0] != r_row);
    assign out_free    = !r_m_valid || i_m_ready;

    assign o_status.kind        = r_kind;
    assign o_status.tick_live   = !r_pause && (cur_frames != FRAME_W'(1)) && (r_len != '0);
    assign o_status.set_switch  = target_ok && (r_target != r_row);
    assign o_status.link_switch = link_switch;
    assign o_status.div_done    = (r_cnt == '0);
    assign o_status.out_free    = out_free;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dur    <= DUR_W'(100);
            r_cfg_fw     <= FW_W'(32);
            r_cfg_fh     <= FW_W'(32);
            r_cfg_tiu    <= TIU_W'(1);
            r_cfg_frames <= TABLE_W'(32'h0101_0101);
            r_cfg_links  <= {LINKS_W{1'b1}};
            r_cfg_srow   <= '0;
            r_cfg_soff   <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DURATION:  r_cfg_dur    <= i_cfg_data[DUR_W-1:0];
                CFG_WIDTH:     r_cfg_fw     <= i_cfg_data[FW_W-1:0];
                CFG_HEIGHT:    r_cfg_fh     <= i_cfg_data[FW_W-1:0];
                CFG_TIMELINES: r_cfg_tiu    <= i_cfg_data[TIU_W-1:0];
                CFG_FRAMES:    r_cfg_frames <= i_cfg_data[TABLE_W-1:0];
                CFG_LINKS:     r_cfg_links  <= i_cfg_data[LINKS_W-1:0];
                CFG_START_ROW: r_cfg_srow   <= i_cfg_data[ROW_W-1:0];
                CFG_START_OFS: r_cfg_soff   <= i_cfg_data[OFFSET_W-1:0];
                default:       r_cfg_dur    <= r_cfg_dur;
            endcase
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind    <= t_kind'(i_kind);
            r_elapsed <= i_elapsed;
            r_target  <= i_target_row;
            r_emit_sw <= i_emit_on_switch;
            r_pval    <= i_pause_value;
        end
    end

    // Animation state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_time   <= '0;
            r_frame  <= '0;
            r_forced <= 1'b0;
            r_len    <= '0;
            r_pause  <= 1'b0;
            r_emit   <= 1'b0;
            r_bad    <= 1'b0;
        end else if (i_cmd.capture) begin
            r_emit <= 1'b0;
            r_bad  <= 1'b0;
        end else if (i_cmd.start_apply) begin
            r_row    <= start_ok ? r_cfg_srow : '0;
            r_bad    <= !start_ok;
            r_time   <= r_cfg_soff;
            r_forced <= 1'b1;
            r_pause  <= 1'b0;
        end else if (i_cmd.pause_apply) begin
            r_pause <= r_pval;
        end else if (i_cmd.set_apply) begin
            if (!target_ok) begin
                r_bad <= 1'b1;
            end else if (r_target != r_row) begin
                r_row   <= r_target;
                r_time  <= '0;
                r_frame <= '0;
                r_emit  <= r_emit_sw;
            end
        end else if (i_cmd.tick_apply) begin
            r_time <= r_rem[TIME_W-1:0];
            if (r_wrap) begin
                r_forced <= 1'b1;
            end
            if (link_switch) begin
                r_row   <= link[ROW_W-1:0];
                r_frame <= '0;
            end
        end else if (i_cmd.len_load) begin
            r_len <= LEN_W'(dur_eff) * LEN_W'(cur_frames);
        end else if (i_cmd.frame_apply) begin
            if (r_forced || (quot_frame != r_frame)) begin
                r_frame <= quot_frame;
                r_emit  <= 1'b1;
            end
            r_forced <= 1'b0;
        end
    end

    // Divider: remainder of the new time by the row length, then the frame index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.mod_load) begin
            r_cnt <= CNT_W'(MOD_STEPS);
        end else if (i_cmd.frame_load) begin
            r_cnt <= CNT_W'(FRAME_STEPS);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_load) begin
            r_rem  <= '0;
            r_dvd  <= sum;
            r_dsr  <= r_len;
            r_wrap <= linked && (sum >= {1'b0, r_len});
        end else if (i_cmd.frame_load) begin
            // The upper bits already reaching the duration mean an index past 255.
            r_sat <= (r_time[TIME_W-1:FRAME_W] >= dur_eff);
            r_rem <= SUM_W'(r_time[TIME_W-1:FRAME_W]);
            r_dvd <= {r_time[FRAME_W-1:0], {(SUM_W-FRAME_W){1'b0}}};
            r_dsr <= LEN_W'(dur_eff);
        end else if (i_cmd.div_step) begin
            r_rem <= step_ge ? (shifted - {1'b0, r_dsr}) : shifted;
            r_dvd <= {r_dvd[SUM_W-2:0], step_ge};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_emit  <= r_emit;
            r_x       <= r_emit ? (X_W'(r_frame) * X_W'(r_cfg_fw)) : '0;
            r_y       <= r_emit ? (Y_W'(r_row) * Y_W'(r_cfg_fh)) : '0;
            r_w       <= r_emit ? r_cfg_fw : '0;
            r_h       <= r_emit ? r_cfg_fh : '0;
            r_o_row   <= r_row;
            r_o_pause <= r_pause;
            r_o_bad   <= r_bad;
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_m_user  = r_o_emit;
    assign o_m_data  = {2'b00, r_o_bad, r_o_pause, r_o_row, r_h, r_w, r_y, r_x};

endmodule

// ===== rtl/sprite_animation_sequencer.sv =====
// Channel     Direction  Handshake                         Payload
// s_axis      in         i_s_axis_tvalid / o_s_axis_tready  tdata 24 b, tuser 2 b
// m_axis      out        o_m_axis_tvalid / i_m_axis_tready  tdata 64 b, tuser 1 b
// cfg         in         i_cfg_valid / o_cfg_ready          index 3 b, data 32 b
//
// A tick that advances time runs a 25-step shift-subtract remainder by the timeline
// length and then an 8-step frame division, both on one shared divider unit; when a
// link moves it to another timeline, the new length is loaded between the two. Start
// items load the length and divide for the frame; set-timeline items load the length
// only when they switch; pause items and idle ticks go straight to the output register.
// One item is worked on at a time; the next one is taken as soon as the result has
// moved into the output register, even while that result still waits for i_m_axis_tready.
// Reset is synchronous and active low; it restores the register defaults and clears
// the animation state. Configuration writes are always taken.
module sprite_animation_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // elapsed [15:0], target_row [17:16], emit_on_switch [18], pause_value [19], zeros above
    input  logic [sas_pkg::S_DATA_W-1:0]       i_s_axis_tdata,
    // kind [1:0]
    input  logic [sas_pkg::S_USER_W-1:0]       i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // sheet_x [19:0], sheet_y [33:20], rect_width [45:34], rect_height [57:46],
    // active_row [59:58], is_paused [60], bad_row [61], zeros above
    output logic [sas_pkg::M_DATA_W-1:0]       o_m_axis_tdata,
    // frame_valid [0]
    output logic [sas_pkg::M_USER_W-1:0]       o_m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sas_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sas_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sas_pkg::*;

    t_cmd    s_cmd;
    t_status s_status;
    logic    s_in_ready;

    // The register file never stalls a write.
    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = s_in_ready;

    sas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (s_status),
        .o_in_ready (s_in_ready),
        .o_cmd      (s_cmd)
    );

    sas_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (s_cmd),
        .o_status         (s_status),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_s_axis_tuser[1:0]),
        .i_elapsed        (i_s_axis_tdata[15:0]),
        .i_target_row     (i_s_axis_tdata[17:16]),
        .i_emit_on_switch (i_s_axis_tdata[18]),
        .i_pause_value    (i_s_axis_tdata[19]),
        .i_m_ready        (i_m_axis_tready),
        .o_m_valid        (o_m_axis_tvalid),
        .o_m_data         (o_m_axis_tdata),
        .o_m_user         (o_m_axis_tuser)
    );

    // In the cycle after an input transfer the block is busy.
    a_busy_after_transfer : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready
    ) else $error("input accepted twice in a row");

    // A result without a rectangle carries zeros in the rectangle fields.
    a_no_rect_zero : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata[57:0] == '0)
    ) else $error("rectangle fields set without frame_valid");

    // The shared divider is never mid-run while the block takes a new item.
    a_div_idle : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> s_status.div_done
    ) else $error("divider still running while ready");

endmodule
